// ===== hdl/tvg_pkg.sv =====
// Shared constants, codes and types for the four-voice tone generator.
// No dependencies; every other file of the block but tvg_ram uses it by scoped names.
`timescale 1ns / 1ps

package tvg_pkg;

  localparam int NUM_VOICES_DEF = 4;
  localparam int MAX_VOICES     = 4;
  localparam int VOICE_W        = 2;
  localparam int PHASE_W        = 31;
  localparam int VOL_W          = 8;
  localparam int WAVE_W         = 2;
  localparam int NOISE_W        = 4;
  localparam int MIX_W          = 10;
  localparam int LEVEL_BITS     = 10;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int OUT_DEPTH      = 4;
  localparam int CRED_W         = 3;

  localparam logic [PHASE_W-1:0]    PHASE_HALF    = 31'h4000_0000;
  localparam logic [CFG_DATA_W-1:0] VOLUMES_RESET = 32'h3f3f_3f3f;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP0   = 3'd0,
    REG_STEP1   = 3'd1,
    REG_STEP2   = 3'd2,
    REG_STEP3   = 3'd3,
    REG_VOLUMES = 3'd4,
    REG_WAVES   = 3'd5
  } cfg_reg_e;

  typedef enum logic [WAVE_W-1:0] {
    WAVE_SQUARE   = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_NOISE    = 2'd3
  } wave_e;

  typedef struct packed {
    logic               valid;
    logic               first;
    logic               last;
    logic               noise;
    logic [VOICE_W-1:0] voice;
  } voice_ctl_t;

  typedef struct packed {
    logic             valid;
    logic [MIX_W-1:0] level;
  } result_t;

endpackage

// ===== hdl/tvg_if.sv =====
// Request channel interfaces of the tone generator: noise input and mix output.
// Depends on tvg_pkg for field widths.
`timescale 1ns / 1ps

interface tvg_noise_if;
  logic                        valid;
  logic                        ready;
  logic [tvg_pkg::NOISE_W-1:0] noise_bits;

  modport source (output valid, output noise_bits, input ready);
  modport sink   (input valid, input noise_bits, output ready);
endinterface

interface tvg_mix_if;
  logic                      valid;
  logic                      ready;
  logic [tvg_pkg::MIX_W-1:0] mix_level;

  modport source (output valid, output mix_level, input ready);
  modport sink   (input valid, input mix_level, output ready);
endinterface

// ===== hdl/tvg_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tvg_voice_pipe.sv =====
// Per-voice pipeline: phase RAM read, phase update and write-back, level, mix.
// Depends on tvg_pkg and tvg_ram.
`timescale 1ns / 1ps

module tvg_voice_pipe #(
  parameter int NUM_VOICES = tvg_pkg::NUM_VOICES_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  tvg_pkg::voice_ctl_t                         issue_i,
  input  logic [NUM_VOICES-1:0][tvg_pkg::PHASE_W-1:0] step_i,
  input  logic [tvg_pkg::CFG_DATA_W-1:0]              volumes_i,
  input  logic [2*tvg_pkg::MAX_VOICES-1:0]            waves_i,
  output tvg_pkg::result_t                            result_o
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int PW = tvg_pkg::PHASE_W;
  localparam int LW = tvg_pkg::VOL_W;
  localparam int MW = tvg_pkg::MIX_W;

  tvg_pkg::voice_ctl_t b_q, c_q, d_q;
  logic [NUM_VOICES-1:0] phase_valid_q;
  logic                  fwd_valid_q;
  logic [VW-1:0]         fwd_addr_q;
  logic [PW-1:0]         fwd_data_q;
  logic [PW-1:0]         ram_rdata;
  logic [PW-1:0]         phase_old;
  logic [PW:0]           phase_sum;
  logic [PW-1:0]         phase_new;
  logic [VW-1:0]         b_addr;
  logic [PW-1:0]         c_phase_q;
  logic [LW-1:0]         c_vol;
  tvg_pkg::wave_e        c_kind;
  logic [PW-21:0]        mul_a;
  logic [PW-21+LW:0]     prod;
  logic [LW:0]           tri_t;
  logic [LW:0]           tri_r;
  logic [LW-1:0]         level_d;
  logic [LW-1:0]         d_level_q;
  logic [MW-1:0]         acc_q;
  logic [MW-1:0]         acc_sum;

  assign b_addr = b_q.voice[VW-1:0];

  tvg_ram #(
    .WIDTH (PW),
    .DEPTH (NUM_VOICES)
  ) u_phase_ram (
    .clk_i   (clk_i),
    .we_i    (b_q.valid),
    .waddr_i (b_addr),
    .wdata_i (phase_new),
    .re_i    (issue_i.valid),
    .raddr_i (issue_i.voice[VW-1:0]),
    .rdata_o (ram_rdata)
  );

  // write in flight during the read: take the fresh value
  always_comb begin
    if (fwd_valid_q && (fwd_addr_q == b_addr)) begin
      phase_old = fwd_data_q;
    end else if (phase_valid_q[b_addr]) begin
      phase_old = ram_rdata;
    end else begin
      phase_old = '0;
    end
    phase_sum = {1'b0, phase_old} + {1'b0, step_i[b_addr]};
    // sum above all-ones: subtract all-ones once, i.e. drop the carry and add one
    phase_new = phase_sum[PW] ? (phase_sum[PW-1:0] + PW'(1)) : phase_sum[PW-1:0];
  end

  always_comb begin
    c_vol  = volumes_i[c_q.voice*LW +: LW];
    c_kind = tvg_pkg::wave_e'(waves_i[c_q.voice*tvg_pkg::WAVE_W +: tvg_pkg::WAVE_W]);
    if (c_kind == tvg_pkg::WAVE_SAW) begin
      mul_a = {1'b0, c_phase_q[PW-1:PW-tvg_pkg::LEVEL_BITS]};
    end else begin
      mul_a = c_phase_q[PW-1:PW-tvg_pkg::LEVEL_BITS-1];
    end
    prod  = mul_a * c_vol;
    tri_t = prod[PW-21+LW:tvg_pkg::LEVEL_BITS];
    tri_r = (tri_t < {1'b0, c_vol}) ? tri_t : ({c_vol, 1'b0} - tri_t);
    case (c_kind)
      tvg_pkg::WAVE_SQUARE:   level_d = (c_phase_q > tvg_pkg::PHASE_HALF) ? c_vol : '0;
      tvg_pkg::WAVE_SAW:      level_d = tri_t[LW-1:0];
      tvg_pkg::WAVE_TRIANGLE: level_d = tri_r[LW-1:0];
      tvg_pkg::WAVE_NOISE:    level_d = c_q.noise ? c_vol : '0;
      default:                level_d = '0;
    endcase
  end

  assign acc_sum = (d_q.first ? '0 : acc_q) + MW'(d_level_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_q           <= '0;
      c_q           <= '0;
      d_q           <= '0;
      phase_valid_q <= '0;
      fwd_valid_q   <= 1'b0;
    end else begin
      b_q         <= issue_i;
      c_q         <= b_q;
      d_q         <= c_q;
      fwd_valid_q <= b_q.valid;
      if (b_q.valid) begin
        phase_valid_q[b_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_addr_q <= b_addr;
    fwd_data_q <= phase_new;
    c_phase_q  <= phase_new;
    d_level_q  <= level_d;
    if (d_q.valid) begin
      acc_q <= acc_sum;
    end
  end

  assign result_o.valid = d_q.valid && d_q.last;
  assign result_o.level = acc_sum;

endmodule

// ===== hdl/tvg_out_fifo.sv =====
// Small result queue between the mixer and the output channel.
// Depends on tvg_pkg.
`timescale 1ns / 1ps

module tvg_out_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tvg_pkg::result_t          push_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output logic [tvg_pkg::MIX_W-1:0] data_o
);

  localparam int PTR_W = $clog2(tvg_pkg::OUT_DEPTH);

  logic [tvg_pkg::MIX_W-1:0]  mem_q [tvg_pkg::OUT_DEPTH];
  logic [PTR_W-1:0]           wr_ptr_q, rd_ptr_q;
  logic [tvg_pkg::CRED_W-1:0] count_q, count_d;

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i.valid && !(pop_i && valid_o)) begin
      count_d = count_q + tvg_pkg::CRED_W'(1);
    end else if (!push_i.valid && pop_i && valid_o) begin
      count_d = count_q - tvg_pkg::CRED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i.valid) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.level;
    end
  end

endmodule

// ===== hdl/four_voice_tone_generator_top.sv =====
// Top level of the four-voice tone generator: config registers, voice issue, credits.
// Depends on tvg_pkg, tvg_if, tvg_voice_pipe and tvg_out_fifo.
//
//   channel   dir  fields                 accepted when
//   noise_if  in   noise_bits[3:0]        valid && ready
//   mix_if    out  mix_level[9:0]         valid && ready
//   cfg       in   cfg_index_i, wdata     cfg_we_i
//
// An item issues one phase RAM read per voice, and a new request can be taken
// as the last voice issues; the result passes pipe stages b, c and d.
// Phases read as zero after reset through per-voice valid bits; no clear pass.
// Up to OUT_DEPTH results queue at the output; input ready drops when
// OUT_DEPTH requests are outstanding.
`timescale 1ns / 1ps

module four_voice_tone_generator_top #(
  parameter int NUM_VOICES = tvg_pkg::NUM_VOICES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tvg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tvg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tvg_noise_if.sink                      noise_if,
  tvg_mix_if.source                      mix_if
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int CW = tvg_pkg::CRED_W;

  logic [NUM_VOICES-1:0][tvg_pkg::PHASE_W-1:0] step_q;
  logic [tvg_pkg::CFG_DATA_W-1:0]              volumes_q;
  logic [2*tvg_pkg::MAX_VOICES-1:0]            waves_q;

  logic                        busy_q;
  logic [VW-1:0]               cnt_q;
  logic [tvg_pkg::NOISE_W-1:0] noise_q;
  logic [CW-1:0]               pend_q, pend_d;
  logic                        in_accept, out_pop, issue_last;
  tvg_pkg::voice_ctl_t         issue;
  tvg_pkg::result_t            result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= '0;
      volumes_q <= tvg_pkg::VOLUMES_RESET;
      waves_q   <= '0;
    end else if (cfg_we_i) begin
      for (int v = 0; v < NUM_VOICES; v++) begin
        if (cfg_index_i == tvg_pkg::CFG_IDX_W'(int'(tvg_pkg::REG_STEP0) + v)) begin
          step_q[v] <= cfg_wdata_i[tvg_pkg::PHASE_W-1:0];
        end
      end
      case (cfg_index_i)
        tvg_pkg::REG_VOLUMES: volumes_q <= cfg_wdata_i;
        tvg_pkg::REG_WAVES:   waves_q   <= cfg_wdata_i[2*tvg_pkg::MAX_VOICES-1:0];
        default: ;
      endcase
    end
  end

  assign issue_last     = (cnt_q == VW'(NUM_VOICES - 1));
  assign noise_if.ready = (!busy_q || issue_last) && (pend_q < CW'(tvg_pkg::OUT_DEPTH));
  assign in_accept      = noise_if.valid && noise_if.ready;
  assign out_pop        = mix_if.valid && mix_if.ready;

  assign issue.valid = busy_q;
  assign issue.first = (cnt_q == '0);
  assign issue.last  = issue_last;
  assign issue.noise = noise_q[cnt_q];
  assign issue.voice = tvg_pkg::VOICE_W'(cnt_q);

  always_comb begin
    pend_d = pend_q;
    if (in_accept && !out_pop) begin
      pend_d = pend_q + CW'(1);
    end else if (!in_accept && out_pop) begin
      pend_d = pend_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
      if (in_accept) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q && issue_last) begin
        busy_q <= 1'b0;
      end else if (busy_q) begin
        cnt_q <= VW'(cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      noise_q <= noise_if.noise_bits;
    end
  end

  tvg_voice_pipe #(
    .NUM_VOICES (NUM_VOICES)
  ) u_voice_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .issue_i   (issue),
    .step_i    (step_q),
    .volumes_i (volumes_q),
    .waves_i   (waves_q),
    .result_o  (result)
  );

  tvg_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (result),
    .pop_i   (mix_if.ready),
    .valid_o (mix_if.valid),
    .data_o  (mix_if.mix_level)
  );

endmodule

// ===== hdl/tvg_checker.sv =====
// Port-level checks of the tone generator, bound to the top level.
// Depends on tvg_pkg and four_voice_tone_generator_top.
`timescale 1ns / 1ps

module tvg_checker #(
  parameter int NUM_VOICES = tvg_pkg::NUM_VOICES_DEF
) (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [tvg_pkg::MIX_W-1:0] mix_level_i
);

  logic [tvg_pkg::CRED_W:0] pend_q;
  logic                     in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + (tvg_pkg::CRED_W+1)'(in_acc) - (tvg_pkg::CRED_W+1)'(out_acc);
    end
  end

  a_mix_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (mix_level_i <= tvg_pkg::MIX_W'(NUM_VOICES * 255)))
    else $error("mix level above voice count times full volume");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mix_level_i))
    else $error("stalled result changed or dropped");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != '0))
    else $error("result offered without a pending request");

  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (pend_q < (tvg_pkg::CRED_W+1)'(tvg_pkg::OUT_DEPTH)))
    else $error("request taken beyond result queue capacity");

endmodule

bind four_voice_tone_generator_top tvg_checker #(
  .NUM_VOICES (NUM_VOICES)
) u_tvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (noise_if.valid),
  .in_ready_i  (noise_if.ready),
  .out_valid_i (mix_if.valid),
  .out_ready_i (mix_if.ready),
  .mix_level_i (mix_if.mix_level)
);
